// File: hdl/bdle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdle_pkg
// shared types, command and status codes for the bounded deque list engine
// ----------------------------------------------------------------------------
package bdle_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT   = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK    = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT    = 3'd2;
  localparam logic [2:0] CMD_POP_BACK     = 3'd3;
  localparam logic [2:0] CMD_INSERT_AT    = 3'd4;
  localparam logic [2:0] CMD_REMOVE_FIRST = 3'd5;
  localparam logic [2:0] CMD_REMOVE_ALL   = 3'd6;
  localparam logic [2:0] CMD_CLEAR        = 3'd7;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [8:0]         position;
  } bdle_in_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [8:0]         entry_total;
    logic               is_empty;
    logic [1:0]         status;
  } bdle_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;       // latch the incoming word
    logic       append;     // write value at the tail
    logic       drop_last;  // shorten the list by one
    logic       clear;      // empty the list
    logic       st_we;      // write status
    logic [1:0] st_val;
    logic       rd_idx;     // read at the scan index and step it
    logic       put;        // write value at the insert slot
    logic       commit;     // take the compacted count and match status
    logic       rd_front;   // read entry 0
    logic       rd_back;    // read the last entry
    logic       cap_front;  // capture front entry from read data
    logic       finish;     // build the result word
  } bdle_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       shift_none;
    logic       idx_last;
  } bdle_sts_t;

  // commands that run the compaction scan
  function automatic logic is_compact(logic [2:0] c);
    return (c == CMD_POP_FRONT) || (c == CMD_REMOVE_FIRST) || (c == CMD_REMOVE_ALL);
  endfunction

endpackage
`default_nettype wire

// File: hdl/bdle_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdle_dpath
// entry memory, count, scan index and result register
// ----------------------------------------------------------------------------
module bdle_dpath
  import bdle_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire bdle_in_t  in_item,
  input  wire bdle_ctl_t ctl,
  output bdle_sts_t      sts,
  output bdle_out_t      result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 9) ? CW : 9;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         w_r, w_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         idx_d_r;
  logic [AW-1:0]         k_r;
  logic [2:0]            cmd_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [8:0]            pos_r;
  logic                  pend_r;
  logic                  hit_r, hit_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] front_r;
  bdle_out_t             res_r;

  logic                  compact;
  logic                  drop;
  logic                  we;
  logic [AW-1:0]         wa;
  logic                  re;
  logic [AW-1:0]         ra;
  logic [CW-1:0]         count_m1;
  logic [PW-1:0]         pos_x, lim_x;

  assign compact  = is_compact(cmd_r);
  assign count_m1 = count_r - CW'(1);

  // drop decision for the word read in the previous cycle
  always_comb begin
    drop = 1'b0;
    case (cmd_r)
      CMD_POP_FRONT:    drop = (idx_d_r == '0);
      CMD_REMOVE_FIRST: drop = (rdata_r == val_r) && !hit_r;
      CMD_REMOVE_ALL:   drop = (rdata_r == val_r);
      default:          drop = 1'b0;
    endcase
  end

  // write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    if (ctl.append) begin
      we = 1'b1;
      wa = AW'(count_r);
    end else if (ctl.put) begin
      we = 1'b1;
      wa = k_r;
    end else if (pend_r) begin
      if (compact) begin
        we = !drop;
        wa = AW'(w_r);
      end else begin
        we = 1'b1;
        wa = idx_d_r + AW'(1);
      end
    end
  end

  // read port
  always_comb begin
    re = ctl.rd_idx || ctl.rd_front || ctl.rd_back;
    if (ctl.rd_back)       ra = AW'(count_m1);
    else if (ctl.rd_front) ra = '0;
    else                   ra = idx_r;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= (ctl.append || ctl.put) ? val_r : rdata_r;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_comb begin
    count_nxt = count_r;
    w_nxt     = w_r;
    hit_nxt   = hit_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    if (ctl.load) begin
      w_nxt   = '0;
      hit_nxt = 1'b0;
      idx_nxt = is_compact(in_item.command) ? '0 : AW'(count_m1);
    end
    if (pend_r && compact) begin
      if (drop) hit_nxt = 1'b1;
      else      w_nxt   = w_r + CW'(1);
    end
    if (ctl.rd_idx) begin
      idx_nxt = compact ? idx_r + AW'(1) : idx_r - AW'(1);
    end
    if (ctl.append || ctl.put) count_nxt = count_r + CW'(1);
    if (ctl.drop_last)         count_nxt = count_m1;
    if (ctl.clear)             count_nxt = '0;
    if (ctl.st_we)             st_nxt    = ctl.st_val;
    if (ctl.commit) begin
      count_nxt = w_r;
      st_nxt    = hit_r ? ST_DONE : ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= ctl.rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    hit_r   <= hit_nxt;
    st_r    <= st_nxt;
    idx_r   <= idx_nxt;
    idx_d_r <= idx_r;
    if (ctl.load) begin
      cmd_r <= in_item.command;
      val_r <= DATA_WIDTH'(in_item.value);
      pos_r <= in_item.position;
      k_r   <= (in_item.command == CMD_INSERT_AT) ? AW'(in_item.position - 9'd1) : '0;
    end
    if (ctl.cap_front) begin
      front_r <= rdata_r;
    end
    if (ctl.finish) begin
      res_r.front_value <= (count_r == '0) ? '1 : 32'(front_r);
      res_r.back_value  <= (count_r == '0) ? '1 : 32'(rdata_r);
      res_r.entry_total <= 9'(count_r);
      res_r.is_empty    <= (count_r == '0);
      res_r.status      <= st_r;
    end
  end

  // position check: 1 .. max(count, 1)
  assign pos_x = PW'(pos_r);
  assign lim_x = (count_r == '0) ? PW'(1) : PW'(count_r);

  assign sts.cmd        = cmd_r;
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.pos_ok     = (pos_x != '0) && (pos_x <= lim_x);
  assign sts.shift_none = (count_r == CW'(k_r));
  assign sts.idx_last   = compact ? (CW'(idx_r) == count_m1) : (idx_r == k_r);

  assign result = res_r;

  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append |-> (count_r != CW'(DEPTH)))
    else $error("append issued on a full list");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.put |-> (count_r < CW'(DEPTH)))
    else $error("insert issued on a full list");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (w_r <= count_r))
    else $error("compaction grew the list");

endmodule
`default_nettype wire

// File: hdl/bdle_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdle_ctrl
// command sequencer: decode, shift, compaction scan and result readout
// ----------------------------------------------------------------------------
module bdle_ctrl
  import bdle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire bdle_sts_t sts,
  output logic           busy,
  output logic           out_strobe,
  output bdle_ctl_t      ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_SHUP     = 4'd2;
  localparam logic [3:0] S_SHUP_END = 4'd3;
  localparam logic [3:0] S_PUT      = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_SCAN_END = 4'd6;
  localparam logic [3:0] S_RD0      = 4'd7;
  localparam logic [3:0] S_RD1      = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       strobe_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RD0;
        case (sts.cmd)
          CMD_PUSH_FRONT: begin
            if (sts.full) begin
              ctl.st_we  = 1'b1;
              ctl.st_val = ST_FULL;
            end else begin
              state_nxt = sts.shift_none ? S_PUT : S_SHUP;
            end
          end
          CMD_PUSH_BACK: begin
            ctl.st_we = 1'b1;
            if (sts.full) begin
              ctl.st_val = ST_FULL;
            end else begin
              ctl.append = 1'b1;
              ctl.st_val = ST_DONE;
            end
          end
          CMD_POP_BACK: begin
            ctl.st_we = 1'b1;
            if (sts.empty) begin
              ctl.st_val = ST_NONE;
            end else begin
              ctl.drop_last = 1'b1;
              ctl.st_val    = ST_DONE;
            end
          end
          CMD_INSERT_AT: begin
            if (sts.full) begin
              ctl.st_we  = 1'b1;
              ctl.st_val = ST_FULL;
            end else if (!sts.pos_ok) begin
              ctl.st_we  = 1'b1;
              ctl.st_val = ST_NONE;
            end else begin
              state_nxt = sts.shift_none ? S_PUT : S_SHUP;
            end
          end
          CMD_POP_FRONT, CMD_REMOVE_FIRST, CMD_REMOVE_ALL: begin
            if (!sts.empty) state_nxt = S_SCAN;
          end
          default: begin
            ctl.clear  = 1'b1;
            ctl.st_we  = 1'b1;
            ctl.st_val = ST_DONE;
          end
        endcase
      end
      S_SHUP: begin
        ctl.rd_idx = 1'b1;
        if (sts.idx_last) state_nxt = S_SHUP_END;
      end
      S_SHUP_END: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        ctl.put    = 1'b1;
        ctl.st_we  = 1'b1;
        ctl.st_val = ST_DONE;
        state_nxt  = S_RD0;
      end
      S_SCAN: begin
        ctl.rd_idx = 1'b1;
        if (sts.idx_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        state_nxt = S_RD0;
      end
      S_RD0: begin
        ctl.rd_front = 1'b1;
        ctl.commit   = is_compact(sts.cmd);
        state_nxt    = S_RD1;
      end
      S_RD1: begin
        ctl.rd_back   = 1'b1;
        ctl.cap_front = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_FIN);
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while still busy");

endmodule
`default_nettype wire

// File: hdl/bounded_deque_list_engine.sv
`default_nettype none
// push back, pop back, clear and rejected commands go from decode straight to the result
//   readout; push front and insert first shift the entries at and above the slot, and pop
//   front and removals first scan the whole list
// throughput: one command at a time, the next start is taken in the strobe cycle;
//   set by the entry memory moving one word per cycle; the receiver cannot stall
// reset: synchronous active-low, empties the list; memory contents are not cleared
// ----------------------------------------------------------------------------
// bounded_deque_list_engine
// ordered list of signed values in a bounded store, one command per word,
// with push/pop at both ends, positional insert, remove first/all and clear
// ----------------------------------------------------------------------------
module bounded_deque_list_engine
  import bdle_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // command word
  input  wire logic     start,
  input  wire bdle_in_t in_item,
  output logic          busy,
  // result word
  output logic          out_strobe,
  output bdle_out_t     out_item
);

  // command and status between sequencer and datapath
  bdle_ctl_t ctl;
  bdle_sts_t sts;

  // sequencer: decodes the command, runs the shift or compaction scan,
  // then reads front and back entries for the result word
  bdle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .busy       (busy),
    .out_strobe (out_strobe),
    .ctl        (ctl)
  );

  // datapath: entry memory with one write and one registered read port,
  // entries kept packed in order at indices 0 .. count-1
  bdle_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .ctl     (ctl),
    .sts     (sts),
    .result  (out_item)
  );

endmodule
`default_nettype wire
